>>> sv/cerc_pkg.sv
// Shared types and constants for the cloud effective radius cell.
package cerc_pkg;

    typedef struct packed {
        logic [15:0] cloud_fraction;
        logic [31:0] ice_mass;
        logic [31:0] liquid_mass;
        logic [31:0] snow_mass;
        logic [23:0] layer_thickness;
        logic        is_land;
        logic        is_glacier;
        logic [15:0] ice_radius_in;
        logic [15:0] snow_radius_in;
        logic [15:0] droplet_number;
    } item_t;

    typedef struct packed {
        logic [31:0] ice_path;
        logic [31:0] liquid_path;
        logic [31:0] snow_path;
        logic [15:0] crystal_radius;
        logic [15:0] droplet_radius;
        logic [15:0] snow_radius;
    } result_t;

    // values carried alongside each transaction
    typedef struct packed {
        logic [31:0] snow_mass;
        logic [15:0] cr;
        logic [15:0] sr;
        logic [37:0] p1;
        logic        cloudy;
        logic        num_zero;
        logic        div_zero;
        logic [39:0] divisor;
        logic [15:0] d;
        logic [31:0] ip;
        logic [31:0] lp;
        logic        use_calc;
    } side_t;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ICE_MIN    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ICE_MAX    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIQ_MIN    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIQ_MAX    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COND   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_THR   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KAPPA_CONT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KAPPA_MAR  = 4'd7;

    localparam logic [15:0] RST_ICE_MIN    = 16'd0;
    localparam logic [15:0] RST_ICE_MAX    = 16'd65535;
    localparam logic [15:0] RST_LIQ_MIN    = 16'd0;
    localparam logic [15:0] RST_LIQ_MAX    = 16'd65535;
    localparam logic [31:0] RST_MIN_COND   = 32'd1;
    localparam logic [15:0] RST_FRAC_THR   = 16'd0;
    localparam logic [15:0] RST_KAPPA_CONT = 16'd18727;
    localparam logic [15:0] RST_KAPPA_MAR  = 16'd17646;

    // droplet radius scale, um Q6.16
    localparam logic [21:0] R0_Q = 22'd4065529;

    function automatic logic [15:0] clamp16(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
        logic [15:0] t;
        begin
            t = (v > hi) ? hi : v;
            return (t < lo) ? lo : t;
        end
    endfunction

endpackage

>>> sv/cloud_effective_radius_cell.sv
// Cloud effective radius cell: pipelined path division, LWC/N division and cube root.
// Throughput: one transaction per cycle; busy is always low, no stalls.
// Depth is set by the bit-serial 47-step path divider, 60-step LWC/N divider
// and 20-step cube root, one step per stage.
// Reset: async active-low, clears valid bits and config registers to defaults.
module cloud_effective_radius_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  cerc_pkg::item_t                   item,
    output logic                              done,
    output cerc_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [cerc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cerc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cerc_pkg::*;

    localparam int PD   = 47;
    localparam int XD   = 60;
    localparam int CR   = 20;
    localparam int ST_A = PD + 1;
    localparam int ST_B = ST_A + XD + 1;
    localparam int ST_M = ST_B + CR + 1;
    localparam int ST_O = ST_M + 1;

    typedef struct packed {
        logic [15:0] r;
        logic [46:0] q;
    } d1_t;

    typedef struct packed {
        logic [39:0] r;
        logic [59:0] q;
    } d2_t;

    typedef struct packed {
        logic [59:0] x;
        logic [47:0] rem;
        logic [19:0] root;
        logic [39:0] sq;
    } cb_t;

    function automatic d1_t div1_step(d1_t c, logic [15:0] d);
        d1_t         n;
        logic [16:0] t;
        begin
            t = {c.r, c.q[46]};
            if (t >= {1'b0, d})
            begin
                n.r = 16'(t - {1'b0, d});
                n.q = {c.q[45:0], 1'b1};
            end
            else
            begin
                n.r = t[15:0];
                n.q = {c.q[45:0], 1'b0};
            end
            return n;
        end
    endfunction

    function automatic d2_t div2_step(d2_t c, logic [39:0] d);
        d2_t         n;
        logic [40:0] t;
        begin
            t = {c.r, c.q[59]};
            if (t >= {1'b0, d})
            begin
                n.r = 40'(t - {1'b0, d});
                n.q = {c.q[58:0], 1'b1};
            end
            else
            begin
                n.r = t[39:0];
                n.q = {c.q[58:0], 1'b0};
            end
            return n;
        end
    endfunction

    function automatic cb_t cb_step(cb_t c);
        cb_t         n;
        logic [47:0] t;
        logic [47:0] rs;
        begin
            rs  = {c.rem[44:0], c.x[59:57]};
            t   = (48'(c.sq) << 3) + (48'(c.sq) << 2) + (48'(c.root) << 2)
                + (48'(c.root) << 1) + 48'd1;
            n.x = {c.x[56:0], 3'b000};
            if (rs >= t)
            begin
                n.rem  = rs - t;
                n.root = {c.root[18:0], 1'b1};
                n.sq   = 40'((48'(c.sq) << 2) + (48'(c.root) << 2) + 48'd1);
            end
            else
            begin
                n.rem  = rs;
                n.root = {c.root[18:0], 1'b0};
                n.sq   = 40'(48'(c.sq) << 2);
            end
            return n;
        end
    endfunction

    logic [15:0] ice_min_reg, ice_max_reg, liq_min_reg, liq_max_reg;
    logic [31:0] min_cond_reg;
    logic [15:0] frac_thr_reg, kappa_cont_reg, kappa_mar_reg;

    logic        v_reg    [0:ST_O];
    side_t       side_reg [0:ST_M];
    d1_t         ia_reg   [0:PD];
    d1_t         la_reg   [0:PD];
    d2_t         x_reg    [0:XD];
    cb_t         cb_reg   [0:CR];
    logic [57:0] prod_reg;
    result_t     result_reg;

    logic        accept;
    side_t       side_next;
    logic [15:0] kap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ice_min_reg    <= RST_ICE_MIN;
            ice_max_reg    <= RST_ICE_MAX;
            liq_min_reg    <= RST_LIQ_MIN;
            liq_max_reg    <= RST_LIQ_MAX;
            min_cond_reg   <= RST_MIN_COND;
            frac_thr_reg   <= RST_FRAC_THR;
            kappa_cont_reg <= RST_KAPPA_CONT;
            kappa_mar_reg  <= RST_KAPPA_MAR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ICE_MIN:    ice_min_reg    <= cfg_data[15:0];
                REG_ICE_MAX:    ice_max_reg    <= cfg_data[15:0];
                REG_LIQ_MIN:    liq_min_reg    <= cfg_data[15:0];
                REG_LIQ_MAX:    liq_max_reg    <= cfg_data[15:0];
                REG_MIN_COND:   min_cond_reg   <= cfg_data[31:0];
                REG_FRAC_THR:   frac_thr_reg   <= cfg_data[15:0];
                REG_KAPPA_CONT: kappa_cont_reg <= cfg_data[15:0];
                REG_KAPPA_MAR:  kappa_mar_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_comb
    begin
        kap = (item.is_land && !item.is_glacier) ? kappa_cont_reg : kappa_mar_reg;
        side_next.snow_mass = item.snow_mass;
        side_next.cr        = clamp16(item.ice_radius_in, ice_min_reg, ice_max_reg);
        side_next.sr        = (item.snow_mass > min_cond_reg)
                            ? clamp16(item.snow_radius_in, ice_min_reg, ice_max_reg)
                            : ice_min_reg;
        side_next.p1        = 38'(R0_Q) * 38'(kap);
        side_next.cloudy    = item.cloud_fraction > frac_thr_reg;
        side_next.num_zero  = item.droplet_number == 16'd0;
        side_next.div_zero  = (item.droplet_number == 16'd0) ||
                              (item.layer_thickness == 24'd0);
        side_next.divisor   = 40'(item.layer_thickness) * 40'(item.droplet_number);
        side_next.d         = (item.cloud_fraction == 16'd0) ? 16'd1 : item.cloud_fraction;
        side_next.ip        = 32'd0;
        side_next.lp        = 32'd0;
        side_next.use_calc  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= accept;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        ia_reg[0]   <= '{r: 16'd0, q: {item.ice_mass, 15'd0}};
        la_reg[0]   <= '{r: 16'd0, q: {item.liquid_mass, 15'd0}};
    end

    genvar i;
    generate
        for (i = 0; i < ST_O; i++)
        begin : g_valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i+1] <= 1'b0;
                else
                    v_reg[i+1] <= v_reg[i];
            end
        end

        for (i = 0; i < ST_M; i++)
        begin : g_side
            if (i == PD)
            begin : g_paths
                logic [31:0] ip_next, lp_next;
                logic [32:0] sum_next;
                side_t       mid_next;
                always_comb
                begin
                    ip_next  = !side_reg[i].cloudy ? 32'd0
                             : (|ia_reg[PD].q[46:32]) ? 32'hFFFF_FFFF : ia_reg[PD].q[31:0];
                    lp_next  = !side_reg[i].cloudy ? 32'd0
                             : (|la_reg[PD].q[46:32]) ? 32'hFFFF_FFFF : la_reg[PD].q[31:0];
                    sum_next = {1'b0, ip_next} + {1'b0, lp_next};
                    mid_next          = side_reg[i];
                    mid_next.ip       = ip_next;
                    mid_next.lp       = lp_next;
                    mid_next.use_calc = side_reg[i].cloudy &&
                                        (sum_next > {1'b0, min_cond_reg});
                end
                always_ff @(posedge clk)
                begin
                    side_reg[i+1] <= mid_next;
                    x_reg[0]      <= '{r: 40'd0, q: {lp_next, 28'd0}};
                end
            end
            else
            begin : g_pass
                always_ff @(posedge clk)
                    side_reg[i+1] <= side_reg[i];
            end
        end

        for (i = 0; i < PD; i++)
        begin : g_pdiv
            always_ff @(posedge clk)
            begin
                ia_reg[i+1] <= div1_step(ia_reg[i], side_reg[i].d);
                la_reg[i+1] <= div1_step(la_reg[i], side_reg[i].d);
            end
        end

        for (i = 0; i < XD; i++)
        begin : g_xdiv
            always_ff @(posedge clk)
                x_reg[i+1] <= div2_step(x_reg[i], side_reg[ST_A+i].divisor);
        end

        for (i = 0; i < CR; i++)
        begin : g_cbrt
            always_ff @(posedge clk)
                cb_reg[i+1] <= cb_step(cb_reg[i]);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        cb_reg[0] <= '{x: (side_reg[ST_A+XD].div_zero ? 60'd0 : x_reg[XD].q),
                       rem: 48'd0, root: 20'd0, sq: 40'd0};
        prod_reg  <= 58'(side_reg[ST_M-1].p1) * 58'(cb_reg[CR].root);
    end

    logic [15:0] rad_raw, dr_calc;

    always_comb
    begin
        rad_raw = (|prod_reg[57:50]) ? 16'hFFFF : prod_reg[49:34];
        dr_calc = side_reg[ST_M].num_zero ? 16'd0
                : clamp16(rad_raw, liq_min_reg, liq_max_reg);
    end

    always_ff @(posedge clk)
    begin
        result_reg.ice_path       <= side_reg[ST_M].ip;
        result_reg.liquid_path    <= side_reg[ST_M].lp;
        result_reg.snow_path      <= side_reg[ST_M].snow_mass;
        result_reg.crystal_radius <= side_reg[ST_M].use_calc ? side_reg[ST_M].cr : ice_min_reg;
        result_reg.droplet_radius <= side_reg[ST_M].use_calc ? dr_calc : liq_min_reg;
        result_reg.snow_radius    <= side_reg[ST_M].sr;
    end

    assign done   = v_reg[ST_O];
    assign result = result_reg;

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] |-> side_reg[0].d != 16'd0)
        else $error("path divisor is zero");

    a_clear_paths: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_M] && !side_reg[ST_M].cloudy |=>
        result.ice_path == 32'd0 && result.liquid_path == 32'd0)
        else $error("paths not zero for clear cell");

    a_no_droplets: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_M] && side_reg[ST_M].num_zero && side_reg[ST_M].use_calc |=>
        result.droplet_radius == 16'd0)
        else $error("droplet radius not zero without droplets");

endmodule
